>>> hdl/walas_pkg.sv
// walas_pkg: shared field widths, command and status codes for the
// weighted adjacency list store. No dependencies.
`timescale 1ns / 1ps

package walas_pkg;

  // Fixed widths of the channel fields
  localparam int CMD_W       = 2;
  localparam int VERTEX_W    = 8;
  localparam int WEIGHT_IN_W = 16;
  localparam int STATUS_W    = 2;
  localparam int DEG_OUT_W   = 5;
  localparam int CFG_W       = 9;

  // vertex_count after reset
  localparam logic [CFG_W-1:0] VCOUNT_RESET = 9'd256;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_CHANGE = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_RANGE   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

endpackage

>>> hdl/walas_if.sv
// walas_if: valid/ready channel interfaces for commands and results.
// Depends on walas_pkg for field widths.
`timescale 1ns / 1ps

interface walas_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [walas_pkg::CMD_W-1:0]       command;
  logic [walas_pkg::VERTEX_W-1:0]    vertex_a;
  logic [walas_pkg::VERTEX_W-1:0]    vertex_b;
  logic [walas_pkg::WEIGHT_IN_W-1:0] edge_weight;

  modport source (output valid, command, vertex_a, vertex_b, edge_weight, input ready);
  modport sink   (input valid, command, vertex_a, vertex_b, edge_weight, output ready);
endinterface

interface walas_res_if;
  logic                            valid;
  logic                            ready;
  logic [walas_pkg::STATUS_W-1:0]  status;
  logic [walas_pkg::DEG_OUT_W-1:0] degree_a;
  logic [walas_pkg::DEG_OUT_W-1:0] degree_b;

  modport source (output valid, status, degree_a, degree_b, input ready);
  modport sink   (input valid, status, degree_a, degree_b, output ready);
endinterface

>>> hdl/walas_deg_store.sv
// walas_deg_store: per-vertex degree memory, one read and one write port,
// with a zeroing sweep after reset. Standalone; no package use.
`timescale 1ns / 1ps

module walas_deg_store #(
  parameter int NUM_VERTICES = 256,
  parameter int MAX_DEGREE   = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [$clog2(NUM_VERTICES)-1:0]   rd_addr,
  output logic [$clog2(MAX_DEGREE+1)-1:0]   rd_data,
  input  logic                              wr_en,
  input  logic [$clog2(NUM_VERTICES)-1:0]   wr_addr,
  input  logic [$clog2(MAX_DEGREE+1)-1:0]   wr_data,
  output logic                              clearing
);

  localparam int VW = $clog2(NUM_VERTICES);
  localparam int DW = $clog2(MAX_DEGREE + 1);

  logic [DW-1:0] mem [NUM_VERTICES];
  logic [VW-1:0] clr_addr;

  // Zeroing sweep, one entry a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == VW'(NUM_VERTICES - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + VW'(1);
      end
    end
  end

  // Memory: sweep has the write port while clearing
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hdl/walas_list_store.sv
// walas_list_store: neighbour/weight entry memory, one slot per list
// position of each vertex. Slot addresses are built here. No package use.
`timescale 1ns / 1ps

module walas_list_store #(
  parameter int NUM_VERTICES = 256,
  parameter int MAX_DEGREE   = 16,
  parameter int WEIGHT_BITS  = 16,
  parameter int NB_W         = 8
) (
  input  logic                              clk,
  input  logic [$clog2(NUM_VERTICES)-1:0]   rd_vtx,
  input  logic [$clog2(MAX_DEGREE)-1:0]     rd_idx,
  output logic [NB_W-1:0]                   rd_nb,
  output logic [WEIGHT_BITS-1:0]            rd_w,
  input  logic                              wr_en,
  input  logic [$clog2(NUM_VERTICES)-1:0]   wr_vtx,
  input  logic [$clog2(MAX_DEGREE)-1:0]     wr_idx,
  input  logic [NB_W-1:0]                   wr_nb,
  input  logic [WEIGHT_BITS-1:0]            wr_w
);

  localparam int DEPTH   = NUM_VERTICES * MAX_DEGREE;
  localparam int AW      = $clog2(DEPTH);
  localparam int ENTRY_W = NB_W + WEIGHT_BITS;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic [ENTRY_W-1:0] rd_entry;

  // slot = vertex * MAX_DEGREE + position
  assign rd_addr = AW'(AW'(rd_vtx) * AW'(MAX_DEGREE)) + AW'(rd_idx);
  assign wr_addr = AW'(AW'(wr_vtx) * AW'(MAX_DEGREE)) + AW'(wr_idx);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_nb, wr_w};
    end
    rd_entry <= mem[rd_addr];
  end

  assign rd_nb = rd_entry[ENTRY_W-1:WEIGHT_BITS];
  assign rd_w  = rd_entry[WEIGHT_BITS-1:0];

endmodule

>>> hdl/walas_seq.sv
// walas_seq: command sequencer. Reads both degrees; unless refused, works
// each end of the edge in turn (append, search/rewrite, search/swap-remove)
// and registers the result. Depends on walas_pkg and walas_if.
`timescale 1ns / 1ps

module walas_seq #(
  parameter int NUM_VERTICES = 256,
  parameter int MAX_DEGREE   = 16,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  walas_cmd_if.sink                           cmd,
  walas_res_if.source                         res,
  input  logic                                a_ok,
  input  logic                                b_ok,
  input  logic                                clearing,
  output logic [$clog2(NUM_VERTICES)-1:0]     deg_rd_addr,
  input  logic [$clog2(MAX_DEGREE+1)-1:0]     deg_rd_data,
  output logic                                deg_wr_en,
  output logic [$clog2(NUM_VERTICES)-1:0]     deg_wr_addr,
  output logic [$clog2(MAX_DEGREE+1)-1:0]     deg_wr_data,
  output logic [$clog2(NUM_VERTICES)-1:0]     list_rd_vtx,
  output logic [$clog2(MAX_DEGREE)-1:0]       list_rd_idx,
  input  logic [walas_pkg::VERTEX_W-1:0]      list_rd_nb,
  input  logic [WEIGHT_BITS-1:0]              list_rd_w,
  output logic                                list_wr_en,
  output logic [$clog2(NUM_VERTICES)-1:0]     list_wr_vtx,
  output logic [$clog2(MAX_DEGREE)-1:0]       list_wr_idx,
  output logic [walas_pkg::VERTEX_W-1:0]      list_wr_nb,
  output logic [WEIGHT_BITS-1:0]              list_wr_w
);

  localparam int VW  = $clog2(NUM_VERTICES);
  localparam int DW  = $clog2(MAX_DEGREE + 1);
  localparam int DW1 = DW + 1;
  localparam int IW  = $clog2(MAX_DEGREE);
  localparam int XW  = walas_pkg::VERTEX_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RDB,
    S_DECIDE,
    S_SIDE,
    S_APPEND,
    S_SCAN,
    S_MOVE,
    S_WDEG,
    S_DONE
  } state_t;

  state_t              state;
  walas_pkg::cmd_t     cmd_q;
  walas_pkg::status_t  status;
  logic [XW-1:0]       a_q;
  logic [XW-1:0]       b_q;
  logic [WEIGHT_BITS-1:0] w_q;
  logic                a_ok_q;
  logic                b_ok_q;
  logic                same;
  logic                side;
  logic [DW-1:0]       deg_a;
  logic [DW-1:0]       deg_b;
  logic [DW-1:0]       idx;
  logic [IW-1:0]       rd_idx;
  logic [IW-1:0]       pos;
  logic                pend;
  logic                res_valid;
  logic [walas_pkg::STATUS_W-1:0]  res_status;
  logic [walas_pkg::DEG_OUT_W-1:0] res_deg_a;
  logic [walas_pkg::DEG_OUT_W-1:0] res_deg_b;

  logic [VW-1:0]       a_v;
  logic [VW-1:0]       b_v;
  logic [VW-1:0]       cur_v;
  logic [XW-1:0]       cur_nb;
  logic [DW-1:0]       cur_d;
  logic [DW-1:0]       last;
  logic                hit;
  logic                scan_more;
  logic                room;
  logic [DW-1:0]       fin_a;

  assign cmd.ready    = (state == S_IDLE) && !clearing;
  assign res.valid    = res_valid;
  assign res.status   = res_status;
  assign res.degree_a = res_deg_a;
  assign res.degree_b = res_deg_b;

  // Current end of the edge being worked
  always_comb begin
    a_v       = VW'(a_q);
    b_v       = VW'(b_q);
    cur_v     = side ? b_v : a_v;
    cur_nb    = side ? a_q : b_q;
    cur_d     = side ? deg_b : deg_a;
    last      = cur_d - DW'(1);
    hit       = pend && (list_rd_nb == cur_nb);
    scan_more = idx < cur_d;
    fin_a     = same ? deg_b : deg_a;
    // deg_b arrives on the read port in S_DECIDE
    if (same) begin
      room = (DW1'(deg_a) + DW1'(2)) <= DW1'(MAX_DEGREE);
    end else begin
      room = (deg_a < DW'(MAX_DEGREE)) && (deg_rd_data < DW'(MAX_DEGREE));
    end
  end

  // Memory port control
  always_comb begin
    deg_rd_addr = (state == S_IDLE) ? VW'(cmd.vertex_a) : b_v;
    deg_wr_en   = (state == S_WDEG);
    deg_wr_addr = cur_v;
    deg_wr_data = cur_d;

    list_rd_vtx = cur_v;
    list_rd_idx = (state == S_SCAN && hit) ? last[IW-1:0] : idx[IW-1:0];

    list_wr_en  = (state == S_APPEND) || (state == S_MOVE) ||
                  (state == S_SCAN && hit && cmd_q == walas_pkg::CMD_CHANGE);
    list_wr_vtx = cur_v;
    list_wr_nb  = cur_nb;
    list_wr_w   = w_q;
    case (state)
      S_APPEND: list_wr_idx = cur_d[IW-1:0];
      S_MOVE: begin
        list_wr_idx = pos;
        list_wr_nb  = list_rd_nb;
        list_wr_w   = list_rd_w;
      end
      default:  list_wr_idx = rd_idx;
    endcase
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      // Result register: loaded from S_DONE, cleared once taken
      if (state == S_DONE && (!res_valid || res.ready)) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.valid && cmd.ready) begin
            cmd_q  <= walas_pkg::cmd_t'(cmd.command);
            a_q    <= cmd.vertex_a;
            b_q    <= cmd.vertex_b;
            w_q    <= WEIGHT_BITS'(cmd.edge_weight);
            a_ok_q <= a_ok;
            b_ok_q <= b_ok;
            same   <= (cmd.vertex_a == cmd.vertex_b);
            status <= walas_pkg::ST_DONE;
            side   <= 1'b0;
            state  <= S_RDB;
          end
        end
        S_RDB: begin
          deg_a <= deg_rd_data;
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          deg_b <= deg_rd_data;
          if (!(a_ok_q && b_ok_q)) begin
            status <= walas_pkg::ST_RANGE;
            state  <= S_DONE;
          end else begin
            case (cmd_q)
              walas_pkg::CMD_ADD: begin
                if (room) begin
                  state <= S_SIDE;
                end else begin
                  status <= walas_pkg::ST_FULL;
                  state  <= S_DONE;
                end
              end
              walas_pkg::CMD_DELETE, walas_pkg::CMD_CHANGE: state <= S_SIDE;
              default: state <= S_DONE;
            endcase
          end
        end
        S_SIDE: begin
          idx  <= '0;
          pend <= 1'b0;
          // a self-loop's second end sees the first end's update
          if (side && same) begin
            deg_b <= deg_a;
          end
          state <= (cmd_q == walas_pkg::CMD_ADD) ? S_APPEND : S_SCAN;
        end
        S_APPEND: begin
          if (side) begin
            deg_b <= deg_b + DW'(1);
          end else begin
            deg_a <= deg_a + DW'(1);
          end
          state <= S_WDEG;
        end
        S_SCAN: begin
          // reads run one ahead of the compare
          if (hit) begin
            pos   <= rd_idx;
            state <= (cmd_q == walas_pkg::CMD_DELETE) ? S_MOVE : S_WDEG;
          end else if (scan_more) begin
            rd_idx <= idx[IW-1:0];
            idx    <= idx + DW'(1);
            pend   <= 1'b1;
          end else begin
            status <= walas_pkg::ST_MISSING;
            state  <= S_WDEG;
          end
        end
        S_MOVE: begin
          if (side) begin
            deg_b <= last;
          end else begin
            deg_a <= last;
          end
          state <= S_WDEG;
        end
        S_WDEG: begin
          if (!side) begin
            side  <= 1'b1;
            state <= S_SIDE;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!res_valid || res.ready) begin
            res_status <= status;
            res_deg_a  <= a_ok_q ? walas_pkg::DEG_OUT_W'(fin_a) : '0;
            res_deg_b  <= b_ok_q ? walas_pkg::DEG_OUT_W'(deg_b) : '0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/weighted_adjacency_list_store.sv
// Weighted adjacency list store, top level: one command at a time; the next
// is taken once the result is loaded. Delete and change search the list of
// each end one entry a cycle through the list memory port; add appends.
// Reset: degree memory swept to zero; vertex_count 256.
`timescale 1ns / 1ps

module weighted_adjacency_list_store #(
  parameter int NUM_VERTICES = 256,
  parameter int MAX_DEGREE   = 16,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [walas_pkg::CFG_W-1:0]   cfg_wr_data,
  walas_cmd_if.sink                     cmd,
  walas_res_if.source                   res
);

  localparam int VW = $clog2(NUM_VERTICES);
  localparam int DW = $clog2(MAX_DEGREE + 1);
  localparam int IW = $clog2(MAX_DEGREE);
  localparam int XW = walas_pkg::VERTEX_W;

  logic [walas_pkg::CFG_W-1:0] vertex_count;
  logic                        a_ok;
  logic                        b_ok;
  logic                        clearing;

  logic [VW-1:0]          deg_rd_addr;
  logic [DW-1:0]          deg_rd_data;
  logic                   deg_wr_en;
  logic [VW-1:0]          deg_wr_addr;
  logic [DW-1:0]          deg_wr_data;
  logic [VW-1:0]          list_rd_vtx;
  logic [IW-1:0]          list_rd_idx;
  logic [XW-1:0]          list_rd_nb;
  logic [WEIGHT_BITS-1:0] list_rd_w;
  logic                   list_wr_en;
  logic [VW-1:0]          list_wr_vtx;
  logic [IW-1:0]          list_wr_idx;
  logic [XW-1:0]          list_wr_nb;
  logic [WEIGHT_BITS-1:0] list_wr_w;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= walas_pkg::VCOUNT_RESET;
    end else if (cfg_wr_en) begin
      vertex_count <= cfg_wr_data;
    end
  end

  // Range check against min(vertex_count, NUM_VERTICES)
  assign a_ok = ({1'b0, cmd.vertex_a} < vertex_count) &&
                (32'(cmd.vertex_a) < 32'(NUM_VERTICES));
  assign b_ok = ({1'b0, cmd.vertex_b} < vertex_count) &&
                (32'(cmd.vertex_b) < 32'(NUM_VERTICES));

  walas_deg_store #(
    .NUM_VERTICES (NUM_VERTICES),
    .MAX_DEGREE   (MAX_DEGREE)
  ) u_deg_store (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (deg_rd_addr),
    .rd_data  (deg_rd_data),
    .wr_en    (deg_wr_en),
    .wr_addr  (deg_wr_addr),
    .wr_data  (deg_wr_data),
    .clearing (clearing)
  );

  walas_list_store #(
    .NUM_VERTICES (NUM_VERTICES),
    .MAX_DEGREE   (MAX_DEGREE),
    .WEIGHT_BITS  (WEIGHT_BITS),
    .NB_W         (XW)
  ) u_list_store (
    .clk    (clk),
    .rd_vtx (list_rd_vtx),
    .rd_idx (list_rd_idx),
    .rd_nb  (list_rd_nb),
    .rd_w   (list_rd_w),
    .wr_en  (list_wr_en),
    .wr_vtx (list_wr_vtx),
    .wr_idx (list_wr_idx),
    .wr_nb  (list_wr_nb),
    .wr_w   (list_wr_w)
  );

  walas_seq #(
    .NUM_VERTICES (NUM_VERTICES),
    .MAX_DEGREE   (MAX_DEGREE),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .res         (res),
    .a_ok        (a_ok),
    .b_ok        (b_ok),
    .clearing    (clearing),
    .deg_rd_addr (deg_rd_addr),
    .deg_rd_data (deg_rd_data),
    .deg_wr_en   (deg_wr_en),
    .deg_wr_addr (deg_wr_addr),
    .deg_wr_data (deg_wr_data),
    .list_rd_vtx (list_rd_vtx),
    .list_rd_idx (list_rd_idx),
    .list_rd_nb  (list_rd_nb),
    .list_rd_w   (list_rd_w),
    .list_wr_en  (list_wr_en),
    .list_wr_vtx (list_wr_vtx),
    .list_wr_idx (list_wr_idx),
    .list_wr_nb  (list_wr_nb),
    .list_wr_w   (list_wr_w)
  );

endmodule

>>> bench/walas_checker.sv
// walas_checker: watches the command and result channels of the weighted
// adjacency list store, predicts each result and compares it.
// Depends on walas_pkg and the channel interfaces in walas_if.sv.
`timescale 1ns / 1ps

module walas_checker #(
  parameter int NUM_VERTICES = 256,
  parameter int MAX_DEGREE   = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [walas_pkg::CFG_W-1:0] cfg_wr_data,
  walas_cmd_if                        cmd_mon,
  walas_res_if                        res_mon,
  output int                          mismatches,
  output int                          pending
);

  localparam int XW  = walas_pkg::VERTEX_W;
  localparam int WW  = walas_pkg::WEIGHT_IN_W;
  localparam int DOW = walas_pkg::DEG_OUT_W;

  typedef struct packed {
    walas_pkg::status_t status;
    logic [DOW-1:0]     deg_a;
    logic [DOW-1:0]     deg_b;
  } outcome_t;

  // Shadow copy of the graph
  logic [XW-1:0]               nbr_mem [NUM_VERTICES][MAX_DEGREE];
  logic [WW-1:0]               wgt_mem [NUM_VERTICES][MAX_DEGREE];
  int                          deg_cnt [NUM_VERTICES];
  logic [walas_pkg::CFG_W-1:0] vcount;

  outcome_t predicted_results[$];
  outcome_t want;
  outcome_t fresh;
  int       fail_tally;

  // First list position of vertex v that names neighbour n, or -1
  function automatic int find_slot(int v, int n);
    int i;
    for (i = 0; i < deg_cnt[v] && i < MAX_DEGREE; i++) begin
      if (nbr_mem[v][i] == n[XW-1:0]) return i;
    end
    return -1;
  endfunction

  function automatic void push_entry(int v, int n, logic [WW-1:0] w);
    nbr_mem[v][deg_cnt[v]] = n[XW-1:0];
    wgt_mem[v][deg_cnt[v]] = w;
    deg_cnt[v]++;
  endfunction

  // Swap-with-last removal
  function automatic bit drop_entry(int v, int n);
    int pos;
    int last;
    pos = find_slot(v, n);
    if (pos < 0) return 1'b0;
    last = deg_cnt[v] - 1;
    nbr_mem[v][pos] = nbr_mem[v][last];
    wgt_mem[v][pos] = wgt_mem[v][last];
    deg_cnt[v] = last;
    return 1'b1;
  endfunction

  function automatic bit set_weight(int v, int n, logic [WW-1:0] w);
    int pos;
    pos = find_slot(v, n);
    if (pos < 0) return 1'b0;
    wgt_mem[v][pos] = w;
    return 1'b1;
  endfunction

  // Applies one command to the shadow graph and returns its result
  function automatic outcome_t apply_command(walas_pkg::cmd_t op, int va, int vb,
                                             logic [WW-1:0] w);
    outcome_t r;
    int       lim;
    bit       in_a;
    bit       in_b;
    bit       hit_a;
    bit       hit_b;
    bit       has_room;
    lim  = (vcount < NUM_VERTICES) ? int'(vcount) : NUM_VERTICES;
    in_a = va < lim;
    in_b = vb < lim;
    r.status = walas_pkg::ST_DONE;
    if (!in_a || !in_b) begin
      r.status = walas_pkg::ST_RANGE;
    end else if (op == walas_pkg::CMD_ADD) begin
      // a self-loop needs two free entries in the one list
      if (va == vb) has_room = deg_cnt[va] + 2 <= MAX_DEGREE;
      else has_room = deg_cnt[va] < MAX_DEGREE && deg_cnt[vb] < MAX_DEGREE;
      if (has_room) begin
        push_entry(va, vb, w);
        push_entry(vb, va, w);
      end else begin
        r.status = walas_pkg::ST_FULL;
      end
    end else if (op == walas_pkg::CMD_DELETE) begin
      hit_a = drop_entry(va, vb);
      hit_b = drop_entry(vb, va);
      if (!hit_a || !hit_b) r.status = walas_pkg::ST_MISSING;
    end else if (op == walas_pkg::CMD_CHANGE) begin
      hit_a = set_weight(va, vb, w);
      hit_b = set_weight(vb, va, w);
      if (!hit_a || !hit_b) r.status = walas_pkg::ST_MISSING;
    end
    r.deg_a = in_a ? DOW'(deg_cnt[va]) : '0;
    r.deg_b = in_b ? DOW'(deg_cnt[vb]) : '0;
    return r;
  endfunction

  // Compare results first, then register writes, then new commands
  always @(posedge clk) begin
    if (rst) begin
      foreach (deg_cnt[v]) deg_cnt[v] = 0;
      vcount = walas_pkg::VCOUNT_RESET;
      predicted_results.delete();
      fail_tally = 0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: unexpected result status %0d degrees %0d %0d", $time,
                   res_mon.status, res_mon.degree_a, res_mon.degree_b);
          fail_tally++;
        end else begin
          want = predicted_results.pop_front();
          if (res_mon.status !== want.status) begin
            $display("%0t: status expected %0d, actual %0d", $time,
                     want.status, res_mon.status);
            fail_tally++;
          end
          if (res_mon.degree_a !== want.deg_a) begin
            $display("%0t: degree_a expected %0d, actual %0d", $time,
                     want.deg_a, res_mon.degree_a);
            fail_tally++;
          end
          if (res_mon.degree_b !== want.deg_b) begin
            $display("%0t: degree_b expected %0d, actual %0d", $time,
                     want.deg_b, res_mon.degree_b);
            fail_tally++;
          end
        end
      end
      if (cfg_wr_en) vcount = cfg_wr_data;
      if (cmd_mon.valid && cmd_mon.ready) begin
        fresh = apply_command(walas_pkg::cmd_t'(cmd_mon.command),
                              int'(cmd_mon.vertex_a),
                              int'(cmd_mon.vertex_b),
                              cmd_mon.edge_weight);
        predicted_results.insert(predicted_results.size(), fresh);
      end
    end
    mismatches <= fail_tally;
    pending    <= predicted_results.size();
  end

endmodule

>>> bench/tb_weighted_adjacency_list_store.sv
// tb_weighted_adjacency_list_store: drives commands and vertex_count writes
// into the store and gives the verdict from walas_checker.
// Depends on walas_pkg, walas_if.sv, walas_checker and the store itself.
`timescale 1ns / 1ps

module tb_weighted_adjacency_list_store;

  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_SEGS    = 11;
  localparam int CW          = walas_pkg::CFG_W;
  localparam int XW          = walas_pkg::VERTEX_W;
  localparam int WW          = walas_pkg::WEIGHT_IN_W;

  logic          clk;
  logic          rst;
  logic          cfg_wr_en;
  logic [CW-1:0] cfg_wr_data;
  int            fail_count;
  int            in_flight;
  int            cycle_count = 0;
  int            send_idle;
  int            recv_idle;
  logic [CW-1:0] vcount_now;

  // vertex_count per random segment, and how many commands each gets
  int vcount_plan [NUM_SEGS] = '{5, 256, 1, 8, 0, 3, 511, 12, 2, 256, 6};
  int seg_items   [NUM_SEGS] = '{130, 110, 30, 120, 30, 110, 100, 120, 100, 100, 126};

  walas_cmd_if cmd_bus ();
  walas_res_if res_bus ();

  weighted_adjacency_list_store dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd_bus),
    .res         (res_bus)
  );

  walas_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd_mon     (cmd_bus),
    .res_mon     (res_bus),
    .mismatches  (fail_count),
    .pending     (in_flight)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Result back-pressure
  always @(posedge clk) begin
    if (rst) begin
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("weighted_adjacency_list_store: mismatch");
      $finish;
    end
  end

  // One command transaction, with random idle cycles ahead of it
  task automatic send_command(walas_pkg::cmd_t op, logic [XW-1:0] va,
                              logic [XW-1:0] vb, logic [WW-1:0] w);
    while ($urandom_range(0, 99) < send_idle) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_bus.valid       <= 1'b1;
    cmd_bus.command     <= op;
    cmd_bus.vertex_a    <= va;
    cmd_bus.vertex_b    <= vb;
    cmd_bus.edge_weight <= w;
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
  endtask

  // Stop sending and wait until every result has come back
  task automatic drain_results();
    cmd_bus.valid <= 1'b0;
    @(posedge clk);
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
  endtask

  task automatic set_vertex_count(logic [CW-1:0] v);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    vcount_now = v;
  endtask

  // Mostly a small cluster of in-range vertices, so edges meet again
  function automatic logic [XW-1:0] pick_vertex();
    int hi;
    int r;
    r  = $urandom_range(0, 99);
    hi = (vcount_now == 0) ? 0 : ((vcount_now > 256) ? 255 : int'(vcount_now) - 1);
    if (r < 10) return XW'($urandom_range(0, 255));
    if (r < 85) return XW'($urandom_range(0, (hi < 9) ? hi : 9));
    return XW'($urandom_range(0, hi));
  endfunction

  function automatic logic [WW-1:0] pick_weight();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '1;
    if (r < 10) return '0;
    return WW'($urandom_range(0, 65535));
  endfunction

  initial begin
    int              seg;
    int              n;
    int              r;
    walas_pkg::cmd_t op;
    logic [XW-1:0]   va;
    logic [XW-1:0]   vb;

    rst                 <= 1'b1;
    cfg_wr_en           <= 1'b0;
    cfg_wr_data         <= walas_pkg::VCOUNT_RESET;
    cmd_bus.valid       <= 1'b0;
    cmd_bus.command     <= walas_pkg::CMD_ADD;
    cmd_bus.vertex_a    <= '0;
    cmd_bus.vertex_b    <= '0;
    cmd_bus.edge_weight <= '0;
    send_idle           = 36;
    recv_idle           = 58;
    vcount_now          = walas_pkg::VCOUNT_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: weight extremes, every command, self-loops, missing edge
    send_command(walas_pkg::CMD_ADD, 8'd0, 8'd255, 16'hFFFF);
    send_command(walas_pkg::CMD_ADD, 8'd0, 8'd0, 16'h0000);
    send_command(walas_pkg::CMD_CHANGE, 8'd0, 8'd255, 16'h8000);
    send_command(walas_pkg::CMD_CHANGE, 8'd0, 8'd0, 16'h1234);
    send_command(walas_pkg::CMD_DELETE, 8'd0, 8'd0, 16'h0000);
    send_command(walas_pkg::CMD_DELETE, 8'd0, 8'd0, 16'hFFFF);
    send_command(walas_pkg::CMD_DELETE, 8'd0, 8'd255, 16'h0000);
    send_command(walas_pkg::CMD_CHANGE, 8'd1, 8'd2, 16'h5A5A);
    send_command(walas_pkg::CMD_UNUSED, 8'd255, 8'd255, 16'hFFFF);
    // fill vertex 9: self-loop refused at fifteen, then full at either end
    repeat (7) send_command(walas_pkg::CMD_ADD, 8'd9, 8'd9, 16'h00FF);
    send_command(walas_pkg::CMD_ADD, 8'd9, 8'd10, 16'h0F0F);
    send_command(walas_pkg::CMD_ADD, 8'd9, 8'd9, 16'h0001);
    send_command(walas_pkg::CMD_ADD, 8'd9, 8'd11, 16'hF0F0);
    send_command(walas_pkg::CMD_ADD, 8'd9, 8'd12, 16'h0002);
    send_command(walas_pkg::CMD_ADD, 8'd12, 8'd9, 16'h0003);
    // out of range at either end, and with no vertex in use
    set_vertex_count(9'd1);
    send_command(walas_pkg::CMD_ADD, 8'd0, 8'd1, 16'h0004);
    send_command(walas_pkg::CMD_ADD, 8'd1, 8'd0, 16'h0005);
    set_vertex_count(9'd0);
    send_command(walas_pkg::CMD_ADD, 8'd0, 8'd0, 16'h0006);

    // Random segments: idling mostly on the receiver, then mostly on the sender, then none
    for (seg = 0; seg < NUM_SEGS; seg++) begin
      if (seg == 4) begin
        send_idle = 58;
        recv_idle = 36;
      end else if (seg == 8) begin
        send_idle = 0;
        recv_idle = 0;
      end
      set_vertex_count(CW'(vcount_plan[seg]));
      for (n = 0; n < seg_items[seg]; n++) begin
        r = $urandom_range(0, 99);
        if (r < 45) op = walas_pkg::CMD_ADD;
        else if (r < 75) op = walas_pkg::CMD_DELETE;
        else if (r < 95) op = walas_pkg::CMD_CHANGE;
        else op = walas_pkg::CMD_UNUSED;
        va = pick_vertex();
        vb = ($urandom_range(0, 99) < 12) ? va : pick_vertex();
        send_command(op, va, vb, pick_weight());
      end
    end

    drain_results();
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("weighted_adjacency_list_store: match");
    end else begin
      $display("weighted_adjacency_list_store: mismatch");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/walas_pkg.sv
hdl/walas_if.sv
hdl/walas_deg_store.sv
hdl/walas_list_store.sv
hdl/walas_seq.sv
hdl/weighted_adjacency_list_store.sv
bench/walas_checker.sv
bench/tb_weighted_adjacency_list_store.sv
